/* sv/ookpw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ookpw_pkg;

    // Defaults for the top-level parameters.
    localparam int FIFO_DEPTH_DEF  = 256;
    localparam int SYNC_PULSES_DEF = 40;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPM   = 2'd0;
    localparam logic [1:0] CFG_GAP   = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    // Register widths and reset values.
    localparam int SPM_W   = 16;
    localparam int GAP_W   = 14;
    localparam int LIMIT_W = 16;
    localparam logic [SPM_W-1:0]   SPM_RESET   = 16'd48;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Segment lengths fit in 30 bits (10000 ms gap at the top sample rate).
    localparam int SEG_W = 30;
    localparam logic [SEG_W-1:0] BLANK_MS = 30'd10;
    localparam logic [SEG_W-1:0] PRE_MS   = 30'd2;

    // Word kinds on the input channel.
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // One queued input word.
    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_value;
        logic       last_byte;
    } item_t;

endpackage

`default_nettype wire

/* sv/ookpw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ookpw_front
    import ookpw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    output logic            head_valid,
    output item_t           head_item,
    input  wire logic       head_pop
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    item_t              q_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]       count_reg, count_next;
    logic               push;
    logic               pop;
    item_t              in_item;

    // Classify the incoming word into a queue entry.
    always_comb begin
        in_item.opcode     = s_tuser;
        in_item.byte_value = s_tdata;
        in_item.last_byte  = s_tlast;
    end

    assign s_tready   = (count_reg != (QAW+1)'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head_item  = q_reg[rd_ptr_reg];

    // Pointer and count updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* sv/ookpw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ookpw_back
    import ookpw_pkg::*;
#(
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
    parameter int SYNC_PULSES = SYNC_PULSES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    input  wire logic               head_valid,
    input  wire item_t              head_item,
    output logic                    head_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int PW = $clog2(SYNC_PULSES + 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_LEAD, PH_SYNC_HI, PH_SYNC_LO, PH_SYNC_TAIL,
        PH_PRE_LO, PH_PRE_HI, PH_DATA, PH_GAP
    } phase_t;

    // Configuration registers and derived segment lengths.
    logic [SPM_W-1:0]   spm_reg;
    logic [GAP_W-1:0]   gap_ms_reg;
    logic [SPM_W-1:0]   ms_eff;
    logic [SEG_W-1:0]   len_ms_reg, len_half_reg, len_pre_reg, len_blank_reg, len_gap_reg;

    // Byte store and its pointers.
    logic [8:0]         store_mem [FIFO_DEPTH];
    logic [8:0]         rd_data_reg;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [AW-1:0]      rp_reg, rp_next;
    logic [AW-1:0]      fsp_reg, fsp_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      cp_reg, cp_next;

    // Frame state.
    phase_t             phase_reg, phase_next;
    logic [SEG_W-1:0]   sc_reg, sc_next;
    logic [PW-1:0]      pc_reg, pc_next;
    logic [2:0]         bp_reg, bp_next;
    logic               second_reg, second_next;
    logic [LIMIT_W-1:0] fl_reg, fl_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [2:0]         out_reg, out_next;

    logic               act;
    logic               store_we;
    logic [SEG_W-1:0]   seg_len;
    logic               seg_level;
    logic               cur_bit;
    logic [AW-1:0]      rp_inc;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign ms_eff  = (spm_reg == '0) ? SPM_W'(1) : spm_reg;
    assign cur_bit = rd_data_reg[3'd7 - bp_reg];
    assign rp_inc  = ptr_inc(rp_reg);
    assign act     = head_valid && (!m_tvalid_reg || m_tready);

    // Length and level of the current segment.
    always_comb begin
        unique case (phase_reg)
            PH_IDLE, PH_LEAD:                    seg_len = len_blank_reg;
            PH_SYNC_HI, PH_SYNC_LO, PH_SYNC_TAIL: seg_len = len_ms_reg;
            PH_PRE_LO, PH_PRE_HI:                seg_len = len_pre_reg;
            PH_DATA:                             seg_len = cur_bit ? len_ms_reg : len_half_reg;
            default:                             seg_len = len_gap_reg;
        endcase
        unique case (phase_reg)
            PH_SYNC_HI, PH_SYNC_TAIL, PH_PRE_HI: seg_level = 1'b1;
            PH_DATA:                             seg_level = bp_reg[0];
            default:                             seg_level = 1'b0;
        endcase
    end

    // One step of the sequencer per cycle while a word waits and the result side
    // is not stalled: a push, a frame start, a sample or a move to the next segment.
    always_comb begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        fsp_next      = fsp_reg;
        fill_next     = fill_reg;
        cp_next       = cp_reg;
        phase_next    = phase_reg;
        sc_next       = sc_reg;
        pc_next       = pc_reg;
        bp_next       = bp_reg;
        second_next   = second_reg;
        fl_next       = fl_reg;
        head_pop      = 1'b0;
        store_we      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;

        if (act) begin
            if (head_item.opcode == OP_PUSH) begin
                head_pop      = 1'b1;
                m_tvalid_next = 1'b1;
                out_next      = {1'b0, fl_reg == '0, 1'b0};
                if (fill_reg < FW'(FIFO_DEPTH)) begin
                    store_we  = 1'b1;
                    wp_next   = ptr_inc(wp_reg);
                    fill_next = fill_reg + 1'b1;
                    if (head_item.last_byte) begin
                        cp_next = cp_reg + 1'b1;
                    end
                    out_next[2] = 1'b1;
                end
            end else if (fl_reg == '0) begin
                head_pop      = 1'b1;
                m_tvalid_next = 1'b1;
                out_next      = 3'b010;
            end else if (phase_reg == PH_IDLE && sc_reg == '0 && cp_reg != '0) begin
                phase_next  = PH_LEAD;
                second_next = 1'b0;
                bp_next     = '0;
                pc_next     = '0;
                rp_next     = fsp_reg;
            end else if (sc_reg < seg_len) begin
                head_pop      = 1'b1;
                m_tvalid_next = 1'b1;
                out_next      = {2'b00, seg_level};
                sc_next       = sc_reg + 1'b1;
            end else begin
                sc_next = '0;
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_LEAD: begin
                        phase_next = PH_SYNC_HI;
                        pc_next    = '0;
                    end
                    PH_SYNC_HI:   phase_next = PH_SYNC_LO;
                    PH_SYNC_LO: begin
                        pc_next    = pc_reg + 1'b1;
                        phase_next = (pc_reg + 1'b1 >= PW'(SYNC_PULSES)) ?
                                     PH_SYNC_TAIL : PH_SYNC_HI;
                    end
                    PH_SYNC_TAIL: phase_next = PH_PRE_LO;
                    PH_PRE_LO:    phase_next = PH_PRE_HI;
                    PH_PRE_HI: begin
                        phase_next = PH_DATA;
                        bp_next    = '0;
                        rp_next    = fsp_reg;
                    end
                    PH_DATA: begin
                        if (bp_reg != 3'd7) begin
                            bp_next = bp_reg + 1'b1;
                        end else begin
                            bp_next = '0;
                            rp_next = rp_inc;
                            if (second_reg) begin
                                if (fill_reg != '0) begin
                                    fill_next = fill_reg - 1'b1;
                                end
                                fsp_next = rp_inc;
                            end
                            if (rd_data_reg[8]) begin
                                if (!second_reg) begin
                                    second_next = 1'b1;
                                    phase_next  = PH_PRE_LO;
                                end else begin
                                    if (cp_reg != '0) begin
                                        cp_next = cp_reg - 1'b1;
                                    end
                                    phase_next = PH_GAP;
                                end
                            end
                        end
                    end
                    default: begin
                        if (fl_reg[LIMIT_W-1]) begin
                            fl_next = '1;
                        end else if (fl_reg != '0) begin
                            fl_next = fl_reg - 1'b1;
                        end
                        phase_next  = PH_IDLE;
                        second_next = 1'b0;
                        // Reaching the limit ends this sample at once.
                        if (fl_reg == LIMIT_W'(1)) begin
                            head_pop      = 1'b1;
                            m_tvalid_next = 1'b1;
                            out_next      = 3'b010;
                        end
                    end
                endcase
            end
        end

        if (cfg_we && cfg_addr == CFG_LIMIT) begin
            fl_next = cfg_wdata;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spm_reg      <= SPM_RESET;
            gap_ms_reg   <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            fsp_reg      <= '0;
            fill_reg     <= '0;
            cp_reg       <= '0;
            phase_reg    <= PH_IDLE;
            sc_reg       <= '0;
            pc_reg       <= '0;
            bp_reg       <= '0;
            second_reg   <= 1'b0;
            fl_reg       <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == CFG_SPM) begin
                spm_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == CFG_GAP) begin
                gap_ms_reg <= cfg_wdata[GAP_W-1:0];
            end
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            fsp_reg      <= fsp_next;
            fill_reg     <= fill_next;
            cp_reg       <= cp_next;
            phase_reg    <= phase_next;
            sc_reg       <= sc_next;
            pc_reg       <= pc_next;
            bp_reg       <= bp_next;
            second_reg   <= second_next;
            fl_reg       <= fl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Segment lengths, output word and byte store; no reset needed.
    always_ff @(posedge aclk) begin
        len_ms_reg    <= SEG_W'(ms_eff);
        len_half_reg  <= SEG_W'(ms_eff >> 1);
        len_pre_reg   <= SEG_W'(ms_eff) * PRE_MS;
        len_blank_reg <= SEG_W'(ms_eff) * BLANK_MS;
        len_gap_reg   <= SEG_W'(gap_ms_reg) * SEG_W'(ms_eff);
        out_reg       <= out_next;
        if (store_we) begin
            store_mem[wp_reg] <= {head_item.last_byte, head_item.byte_value};
        end
        rd_data_reg <= store_mem[rp_next];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, out_reg};

endmodule

`default_nettype wire

/* sv/ook_pulse_width_packet_transmitter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Signals                       | Contents
// ---------+-----+-------------------------------+---------------------------------------
// input    | in  | s_tvalid s_tready s_tdata     | tdata[7:0] byte_value
//          |     | s_tuser s_tlast               | tuser opcode, tlast last_byte
// result   | out | m_tvalid m_tready m_tdata     | tdata[0] level, [1] done, [2] accepted
// config   | in  | cfg_we cfg_addr cfg_wdata     | 0 samples_per_ms, 1 gap_ms, 2 limit
//
// A push or a sample inside a segment is handled in one sequencer step.
// A sample that starts a frame or crosses segment ends first takes a sequencer step
// of its own for each frame start and each segment boundary passed;
// the boundary that uses up the frame limit returns its word in that same step.
// Synchronous active-low reset clears control state; the byte store is not cleared.
// A four-word input queue lets the input side run while the result side stalls.

module ook_pulse_width_packet_transmitter_unit
    import ookpw_pkg::*;
#(
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
    parameter int SYNC_PULSES = SYNC_PULSES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // byte_value
    input  wire logic               s_tuser,   // opcode
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // sample_level, stream_done, byte_accepted
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [LIMIT_W-1:0] cfg_wdata
);

    logic  head_valid;
    item_t head_item;
    logic  head_pop;

    ookpw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    ookpw_back #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .SYNC_PULSES (SYNC_PULSES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ookpw_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int SYNC_COUNT  = 40;
    localparam int STALL_LIMIT = 200000;
    localparam int PEND_DEPTH  = 64;

    typedef enum int {
        SEG_IDLE, SEG_LEAD, SEG_SYNC_HI, SEG_SYNC_LO, SEG_SYNC_TAIL,
        SEG_PRE_LO, SEG_PRE_HI, SEG_DATA, SEG_GAP
    } seg_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // byte_value
    logic        s_tuser = 1'b0;   // opcode
    logic        s_tlast = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // sample_level, stream_done, byte_accepted
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = 2'd0;
    logic [15:0] cfg_wdata = 16'd0;

    ook_pulse_width_packet_transmitter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Transmitter state as the testbench tracks it.
    logic [15:0] rate_ms;
    logic [13:0] gap_len;
    logic [15:0] frames_left;
    logic [8:0]  byte_mem [STORE_DEPTH];
    int          wr_ptr, rd_ptr, frame_ptr, fill, full_packets;
    seg_t        seg;
    int unsigned seg_count;
    int          pulses, bit_idx;
    bit          repeat_copy;

    // Expected result words waiting for the result side, oldest at pend_head.
    logic [2:0]  pend_mem [PEND_DEPTH];
    int          pend_head = 0, pend_tail = 0;
    int          mismatches = 0;
    int          frames_done = 0, samples_sent = 0, bytes_stored = 0, bytes_dropped = 0;
    int          results_seen = 0;
    bit          calm = 1'b0;

    function automatic longint unsigned ms_samples();
        return (rate_ms == 16'd0) ? 1 : longint'(rate_ms);
    endfunction

    // Length in samples of the segment currently being sent.
    function automatic longint unsigned seg_length();
        longint unsigned m;
        m = ms_samples();
        case (seg)
            SEG_IDLE, SEG_LEAD:                    return 10 * m;
            SEG_SYNC_HI, SEG_SYNC_LO, SEG_SYNC_TAIL: return m;
            SEG_PRE_LO, SEG_PRE_HI:                return 2 * m;
            SEG_DATA: return byte_mem[rd_ptr][7 - bit_idx] ? m : m / 2;
            default:                               return longint'(gap_len) * m;
        endcase
    endfunction

    function automatic bit seg_level();
        case (seg)
            SEG_SYNC_HI, SEG_SYNC_TAIL, SEG_PRE_HI: return 1'b1;
            SEG_DATA:                               return bit_idx[0];
            default:                                return 1'b0;
        endcase
    endfunction

    // Move on to the segment that follows the current one.
    function automatic void next_segment();
        bit ends_packet;
        seg_count = 0;
        case (seg)
            SEG_IDLE: ;
            SEG_LEAD: begin
                seg = SEG_SYNC_HI;
                pulses = 0;
            end
            SEG_SYNC_HI: seg = SEG_SYNC_LO;
            SEG_SYNC_LO: begin
                pulses = (pulses + 1) & 8'h7F;
                seg = (pulses >= SYNC_COUNT) ? SEG_SYNC_TAIL : SEG_SYNC_HI;
            end
            SEG_SYNC_TAIL: seg = SEG_PRE_LO;
            SEG_PRE_LO:    seg = SEG_PRE_HI;
            SEG_PRE_HI: begin
                seg = SEG_DATA;
                bit_idx = 0;
                rd_ptr = frame_ptr;
            end
            SEG_DATA: begin
                if (bit_idx < 7) begin
                    bit_idx++;
                end else begin
                    bit_idx = 0;
                    ends_packet = byte_mem[rd_ptr][8];
                    rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
                    // Bytes are released as the second copy goes out.
                    if (repeat_copy) begin
                        if (fill > 0) fill--;
                        frame_ptr = rd_ptr;
                    end
                    if (ends_packet) begin
                        if (!repeat_copy) begin
                            repeat_copy = 1'b1;
                            seg = SEG_PRE_LO;
                        end else begin
                            if (full_packets > 0) full_packets--;
                            seg = SEG_GAP;
                        end
                    end
                end
            end
            default: begin
                if (frames_left[15]) frames_left = 16'hFFFF;
                else if (frames_left != 16'd0) frames_left = frames_left - 16'd1;
                seg = SEG_IDLE;
                repeat_copy = 1'b0;
                frames_done++;
            end
        endcase
    endfunction

    function automatic void clear_state();
        rate_ms = SPM_RESET;
        gap_len = '0;
        frames_left = LIMIT_RESET;
        wr_ptr = 0; rd_ptr = 0; frame_ptr = 0; fill = 0; full_packets = 0;
        seg = SEG_IDLE; seg_count = 0; pulses = 0; bit_idx = 0; repeat_copy = 1'b0;
    endfunction

    // Expected result word {accepted, done, level} for one accepted word.
    function automatic logic [2:0] transmit_word(logic op, logic [7:0] value, logic mark);
        bit level, taken;
        level = 1'b0;
        taken = 1'b0;
        if (op == OP_PUSH) begin
            if (fill < STORE_DEPTH) begin
                byte_mem[wr_ptr] = {mark, value};
                wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
                fill++;
                if (mark) full_packets++;
                taken = 1'b1;
                bytes_stored++;
            end else begin
                bytes_dropped++;
            end
        end else if (frames_left != 16'd0) begin
            forever begin
                if (seg == SEG_IDLE && seg_count == 0 && full_packets > 0) begin
                    seg = SEG_LEAD;
                    repeat_copy = 1'b0;
                    bit_idx = 0;
                    pulses = 0;
                    rd_ptr = frame_ptr;
                end
                if (longint'(seg_count) < seg_length()) break;
                next_segment();
                if (frames_left == 16'd0) break;
            end
            if (frames_left != 16'd0) begin
                level = seg_level();
                seg_count++;
                samples_sent++;
            end
        end
        return {taken, frames_left == 16'd0, level};
    endfunction

    task automatic report(string what, logic [2:0] want, logic [2:0] got);
        $display("MISMATCH %s: expected %0b, got %0b at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    // Result side: compare every accepted word with the oldest expectation.
    always @(posedge aclk) begin
        logic [2:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pend_tail == pend_head) begin
                report("unexpected word", 3'b000, m_tdata[2:0]);
            end else begin
                want = pend_mem[pend_head % PEND_DEPTH];
                pend_head++;
                if (m_tdata[0] !== want[0]) report("sample_level", want, m_tdata[2:0]);
                if (m_tdata[1] !== want[1]) report("stream_done", want, m_tdata[2:0]);
                if (m_tdata[2] !== want[2]) report("byte_accepted", want, m_tdata[2:0]);
            end
        end
    end

    // Receiver stalls in random bursts.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no word moving on either side.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Send one word and record what it should produce.
    task automatic send_word(logic op, logic [7:0] value, logic mark);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        s_tlast  <= mark;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pend_mem[pend_tail % PEND_DEPTH] = transmit_word(op, value, mark);
        pend_tail++;
    endtask

    task automatic send_samples(int count);
        repeat (count) send_word(OP_SAMPLE, 8'($urandom), 1'($urandom));
    endtask

    // Let the block go idle before touching a register.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pend_tail != pend_head) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            CFG_SPM: rate_ms = value;
            CFG_GAP: gap_len = value[13:0];
            default: frames_left = value;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic setup(logic [15:0] rate, logic [13:0] gap, logic [15:0] limit);
        drain();
        write_reg(CFG_SPM, rate);
        write_reg(CFG_GAP, {2'b00, gap});
        write_reg(CFG_LIMIT, limit);
    endtask

    // Reset values: idle low output at the default rate, extreme byte values.
    task automatic test_defaults();
        send_samples(3);
        send_word(OP_PUSH, 8'h00, 1'b0);
        send_word(OP_PUSH, 8'hFF, 1'b0);
        send_word(OP_PUSH, 8'hA5, 1'b1);
        send_samples(4);
    endtask

    // A full frame at one sample per ms, where half-ms zero bits vanish.
    task automatic test_frame();
        setup(16'd1, 14'd0, 16'hFFFF);
        send_samples(140);
        setup(16'd1, 14'd3, 16'hFFFF);
        send_word(OP_PUSH, 8'h3C, 1'b1);
        send_samples(130);
    endtask

    // Frame limit: done after one frame, pushes still stored, zero means none.
    task automatic test_limit();
        setup(16'd1, 14'd2, 16'd1);
        send_word(OP_PUSH, 8'h81, 1'b1);
        send_samples(125);
        send_word(OP_PUSH, 8'h7E, 1'b1);
        send_samples(4);
        setup(16'd1, 14'd0, 16'd0);
        send_samples(3);
        setup(16'd1, 14'd0, 16'h8000);
        send_samples(3);
    endtask

    // Register extremes; zero rate acts as one.
    task automatic test_extremes();
        setup(16'hFFFF, 14'd10000, 16'h7FFF);
        send_samples(5);
        setup(16'd0, 14'd1, 16'hFFFF);
        send_samples(40);
    endtask

    // Mostly well-formed packets of random bytes with plenty of samples.
    task automatic test_random(int words);
        int left, pkt_len, k;
        left = words;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 2) begin
                pkt_len = $urandom_range(1, 3);
                for (k = 0; k < pkt_len; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(OP_PUSH, 8'($urandom), 1'($urandom));
                    else
                        send_word(OP_PUSH, 8'($urandom), k == pkt_len - 1);
                end
                left -= pkt_len;
            end else begin
                send_samples(1);
                left--;
            end
        end
    endtask

    task automatic test_random_phases();
        setup(16'd1, 14'd0, 16'hFFFF);
        test_random(30);
        setup(16'd2, 14'd4, 16'd3);
        test_random(30);
        setup(16'd1, 14'd1, 16'hFFFF);
        test_random(30);
    endtask

    // Fill the byte store with one-byte packets until pushes are dropped.
    task automatic test_full_store();
        int k, pushes;
        setup(16'd1, 14'd0, 16'hFFFF);
        calm = 1'b1;
        pushes = 260 - fill;
        for (k = 0; k < pushes; k++) send_word(OP_PUSH, 8'(k), 1'b1);
        send_word(OP_PUSH, 8'h55, 1'b1);
        test_random(30);
    endtask

    initial begin
        clear_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_frame();
        test_limit();
        test_extremes();
        test_random_phases();
        test_full_store();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pend_tail != pend_head) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d samples, %0d frames, %0d bytes stored, %0d dropped.",
                 samples_sent, frames_done, bytes_stored, bytes_dropped);
        $display("Checked %0d result words across rate, gap and limit settings.",
                 results_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
